/* hdl/crbd_pkg.sv */
// Shared types, constants and helpers for the corotational deformation block.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package crbd_pkg;

  localparam int XW  = 56;  // CORDIC x/y width (chord with 16 guard bits and gain)
  localparam int ZW  = 34;  // angle accumulator, Q.30 radians
  localparam int LCW = 37;  // axial chord component before guard shift

  localparam logic [1:0] REG_COS_THETA = 2'd0;
  localparam logic [1:0] REG_SIN_THETA = 2'd1;
  localparam logic [1:0] REG_INIT_LEN  = 2'd2;

  localparam logic [ZW-1:0] PI_Q30       = 34'd3373259426;
  localparam logic [29:0]   INV_GAIN_Q30 = 30'd652032874;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [31:0]   rot_i;
    logic signed [31:0]   rot_j;
  } cord_t;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic [37:0]          len;
    logic signed [ZW-1:0] angle;
    logic signed [31:0]   rot_i;
    logic signed [31:0]   rot_j;
  } len_t;

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/crbd_xform.sv */
// Front end: rotate both end translations to local axes and form the chord.
// Depends on crbd_pkg; three register stages feeding the CORDIC cell chain.
`default_nettype none

module crbd_xform (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic signed [31:0]  cos_theta,
  input  wire logic signed [31:0]  sin_theta,
  input  wire logic [30:0]         initial_length,
  input  wire logic signed [31:0]  disp_i_x,
  input  wire logic signed [31:0]  disp_i_y,
  input  wire logic signed [31:0]  rot_i,
  input  wire logic signed [31:0]  disp_j_x,
  input  wire logic signed [31:0]  disp_j_y,
  input  wire logic signed [31:0]  rot_j,
  output crbd_pkg::cord_t          cord_q
);

  localparam int LCW = crbd_pkg::LCW;
  localparam logic signed [64:0] HALF30 = 65'sd536870912;

  // stage 1: products
  logic               v1_r;
  logic signed [63:0] cix_r, siy_r, ciy_r, six_r, cjx_r, sjy_r, cjy_r, sjx_r;
  logic signed [31:0] ri1_r, rj1_r;
  // stage 2: local translations
  logic               v2_r;
  logic signed [33:0] lia_r, lit_r, lja_r, ljt_r;
  logic signed [31:0] ri2_r, rj2_r;
  // stage 3 combinational
  logic signed [64:0] sia, sit, sja, sjt;
  logic signed [LCW-1:0] lc;
  logic signed [34:0] dy;
  logic               neg;
  logic signed [LCW-1:0] lc_abs;
  logic signed [34:0] dy_f;
  crbd_pkg::cord_t    cord_nxt;
  crbd_pkg::cord_t    cord_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    if (en) begin
      cix_r <= cos_theta * disp_i_x;
      siy_r <= sin_theta * disp_i_y;
      ciy_r <= cos_theta * disp_i_y;
      six_r <= sin_theta * disp_i_x;
      cjx_r <= cos_theta * disp_j_x;
      sjy_r <= sin_theta * disp_j_y;
      cjy_r <= cos_theta * disp_j_y;
      sjx_r <= sin_theta * disp_j_x;
      ri1_r <= rot_i;
      rj1_r <= rot_j;
      lia_r <= sia[63:30];
      lit_r <= sit[63:30];
      lja_r <= sja[63:30];
      ljt_r <= sjt[63:30];
      ri2_r <= ri1_r;
      rj2_r <= rj1_r;
    end
  end

  // round half up at 2^30
  assign sia = 65'(cix_r) + 65'(siy_r) + HALF30;
  assign sit = 65'(ciy_r) - 65'(six_r) + HALF30;
  assign sja = 65'(cjx_r) + 65'(sjy_r) + HALF30;
  assign sjt = 65'(cjy_r) - 65'(sjx_r) + HALF30;

  always_comb begin
    lc     = $signed({6'b0, initial_length}) + LCW'(lja_r) - LCW'(lia_r);
    dy     = 35'(ljt_r) - 35'(lit_r);
    neg    = lc[LCW-1];
    lc_abs = neg ? -lc : lc;
    dy_f   = neg ? -dy : dy;
    cord_nxt.valid = v2_r;
    cord_nxt.zero  = (lc == '0) && (dy == '0);
    cord_nxt.x     = {crbd_pkg::XW'(lc_abs)} <<< 16;
    cord_nxt.y     = {crbd_pkg::XW'(dy_f)} <<< 16;
    // fold the left half-plane onto the right, starting from +/- pi
    if (!neg) begin
      cord_nxt.z = '0;
    end else if (!dy[34]) begin
      cord_nxt.z = crbd_pkg::PI_Q30;
    end else begin
      cord_nxt.z = -crbd_pkg::PI_Q30;
    end
    cord_nxt.rot_i = ri2_r;
    cord_nxt.rot_j = rj2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cord_r.valid <= 1'b0;
    end else if (en) begin
      cord_r <= cord_nxt;
    end
  end

  assign cord_q = cord_r;

endmodule

`default_nettype wire

/* hdl/crbd_cell.sv */
// One CORDIC vectoring micro-rotation, registered; instantiated once per stage.
// Depends on crbd_pkg for the cell payload type and the arctangent table.
`default_nettype none

module crbd_cell #(
  parameter int IDX = 0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  crbd_pkg::cord_t  d,
  output crbd_pkg::cord_t  q
);

  localparam int XW = crbd_pkg::XW;
  localparam int ZW = crbd_pkg::ZW;
  localparam logic signed [ZW-1:0] ATAN = $signed({2'b00, crbd_pkg::ATAN_Q30[IDX]});

  logic signed [XW-1:0] xs, ys;
  crbd_pkg::cord_t      q_nxt;
  crbd_pkg::cord_t      q_r;

  assign xs = d.x >>> IDX;
  assign ys = d.y >>> IDX;

  always_comb begin
    q_nxt = d;
    if (!d.y[XW-1]) begin
      q_nxt.x = d.x + ys;
      q_nxt.y = d.y - xs;
      q_nxt.z = d.z + ATAN;
    end else begin
      q_nxt.x = d.x - ys;
      q_nxt.y = d.y + xs;
      q_nxt.z = d.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

/* hdl/crbd_scale.sv */
// Back end: gain-corrected chord length and rounded chord angle, two stages.
// Depends on crbd_pkg; fed by the last CORDIC cell.
`default_nettype none

module crbd_scale #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  crbd_pkg::cord_t  d,
  output crbd_pkg::len_t   q
);

  localparam int ZW = crbd_pkg::ZW;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [ZW-1:0] HALF = ZW'(64'sd1 <<< (SH - 1));

  logic                 v1_r, zero1_r;
  logic [50:0]          a_r;
  logic [62:0]          b_r;
  logic signed [ZW-1:0] ang1_r;
  logic signed [31:0]   ri1_r, rj1_r;
  logic signed [ZW-1:0] zr;
  logic [63:0]          lo;
  crbd_pkg::len_t       q_nxt;
  crbd_pkg::len_t       q_r;

  assign zr = (d.z + HALF) >>> SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= d.valid;
    end
    if (en) begin
      // split the 53-bit magnitude so each product stays narrow
      a_r     <= 51'(d.x[52:32]) * 51'(crbd_pkg::INV_GAIN_Q30);
      b_r     <= 63'(d.x[31:0]) * 63'(crbd_pkg::INV_GAIN_Q30) + (63'd1 << 45);
      ang1_r  <= zr;
      zero1_r <= d.zero;
      ri1_r   <= d.rot_i;
      rj1_r   <= d.rot_j;
    end
  end

  always_comb begin
    lo          = {18'b0, a_r[13:0], 32'b0} + 64'(b_r);
    q_nxt.valid = v1_r;
    q_nxt.zero  = zero1_r;
    q_nxt.rot_i = ri1_r;
    q_nxt.rot_j = rj1_r;
    if (zero1_r) begin
      q_nxt.len   = '0;
      q_nxt.angle = '0;
    end else begin
      q_nxt.len   = 38'(a_r[50:14]) + 38'(lo[63:46]);
      q_nxt.angle = ang1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

/* hdl/corotational_basic_deformation.sv */
// Top level: configuration registers, front end, CORDIC cell chain, back end
// and output register. Depends on crbd_pkg, crbd_xform, crbd_cell, crbd_scale.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | end displacements and rotations
//  out_    | output    | out_valid/out_ready| deformation, rotations, length
//  cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// One transaction per cycle while not stalled; the latency grows with CORDIC_STAGES,
// set by the chain of CORDIC cells, one micro-rotation per cell.
// The whole pipeline advances together; it holds only while the output
// register is full and out_ready is low.
// Synchronous active-low reset clears all valid bits and loads register defaults.
`default_nettype none

module corotational_basic_deformation #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_disp_i_x,
  input  wire logic signed [31:0] in_disp_i_y,
  input  wire logic signed [31:0] in_rot_i,
  input  wire logic signed [31:0] in_disp_j_x,
  input  wire logic signed [31:0] in_disp_j_y,
  input  wire logic signed [31:0] in_rot_j,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_axial_deform,
  output logic signed [31:0]      out_basic_rot_i,
  output logic signed [31:0]      out_basic_rot_j,
  output logic [30:0]             out_chord_length,
  output logic                    out_zero_chord
);

  localparam int NCELL = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  logic signed [31:0] cos_r, sin_r;
  logic [30:0]        init_len_r;
  logic               en;
  crbd_pkg::cord_t    chain [NCELL+1];
  crbd_pkg::len_t     sq;

  logic               out_valid_r;
  logic [31:0]        axial_r, bri_r, brj_r;
  logic [30:0]        len_r;
  logic               zero_r;
  logic [31:0]        axial_nxt, bri_nxt, brj_nxt;
  logic [30:0]        len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r      <= 32'sd1073741824;
      sin_r      <= '0;
      init_len_r <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crbd_pkg::REG_COS_THETA: cos_r      <= cfg_data;
        crbd_pkg::REG_SIN_THETA: sin_r      <= cfg_data;
        crbd_pkg::REG_INIT_LEN:  init_len_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  crbd_xform u_xform (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_valid),
    .cos_theta      (cos_r),
    .sin_theta      (sin_r),
    .initial_length (init_len_r),
    .disp_i_x       (in_disp_i_x),
    .disp_i_y       (in_disp_i_y),
    .rot_i          (in_rot_i),
    .disp_j_x       (in_disp_j_x),
    .disp_j_y       (in_disp_j_y),
    .rot_j          (in_rot_j),
    .cord_q         (chain[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    crbd_cell #(.IDX(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (chain[g]),
      .q     (chain[g+1])
    );
  end

  crbd_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     (chain[NCELL]),
    .q     (sq)
  );

  always_comb begin
    axial_nxt = crbd_pkg::sat32($signed({2'b00, sq.len}) - $signed({9'b0, init_len_r}));
    bri_nxt   = crbd_pkg::sat32(40'(sq.rot_i) - 40'(sq.angle));
    brj_nxt   = crbd_pkg::sat32(40'(sq.rot_j) - 40'(sq.angle));
    len_nxt   = (sq.len > 38'h7FFF_FFFF) ? 31'h7FFF_FFFF : sq.len[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq.valid;
    end
    if (en) begin
      axial_r <= axial_nxt;
      bri_r   <= bri_nxt;
      brj_r   <= brj_nxt;
      len_r   <= len_nxt;
      zero_r  <= sq.zero;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_axial_deform = axial_r;
  assign out_basic_rot_i  = bri_r;
  assign out_basic_rot_j  = brj_r;
  assign out_chord_length = len_r;
  assign out_zero_chord   = zero_r;

  a_zero_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && zero_r |-> len_r == '0)
    else $error("zero chord with nonzero length");

  a_zero_axial : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && zero_r |-> axial_r == -{1'b0, init_len_r})
    else $error("zero chord axial deformation is not minus initial length");

  a_hold_back : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(sq) && $stable(chain[0]))
    else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
